>>> hw/rtl/r2q_pkg.sv
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared constants and types of the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package r2q_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	typedef struct packed {
		logic [1:0] branch;
		logic       bad;
	} r2q_ctl_t;

endpackage

>>> hw/rtl/r2q_mtx_if.sv
// ----------------------------------------------------------------------------
// r2q_mtx_if
// Matrix channel: valid/ready plus nine signed matrix entries.
// ----------------------------------------------------------------------------
interface r2q_mtx_if #(
	parameter int DATA_WIDTH = r2q_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r00, r01, r02;
	logic signed [DATA_WIDTH-1:0] r10, r11, r12;
	logic signed [DATA_WIDTH-1:0] r20, r21, r22;

	modport source (
		output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		input  ready
	);
	modport sink (
		input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		output ready
	);
endinterface

>>> hw/rtl/r2q_quat_if.sv
// ----------------------------------------------------------------------------
// r2q_quat_if
// Quaternion channel: valid/ready plus components, branch and error flag.
// ----------------------------------------------------------------------------
interface r2q_quat_if #(
	parameter int DATA_WIDTH = r2q_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] qx, qy, qz, qw;
	logic [1:0]                   branch_taken;
	logic                         bad_input;

	modport source (
		output valid, qx, qy, qz, qw, branch_taken, bad_input,
		input  ready
	);
	modport sink (
		input  valid, qx, qy, qz, qw, branch_taken, bad_input,
		output ready
	);
endinterface

>>> hw/rtl/r2q_front.sv
// ----------------------------------------------------------------------------
// r2q_front
// First stage: trace, branch choice, radicand and the three cross numerators.
// ----------------------------------------------------------------------------
module r2q_front #(
	parameter int DATA_WIDTH = r2q_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = r2q_pkg::FRAC_BITS_DEF,
	parameter int RW         = DATA_WIDTH + 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [DATA_WIDTH-1:0] r00, r01, r02,
	input  logic signed [DATA_WIDTH-1:0] r10, r11, r12,
	input  logic signed [DATA_WIDTH-1:0] r20, r21, r22,
	output logic                         v_s1,
	output r2q_pkg::r2q_ctl_t            ctl_s1,
	output logic [RW-2:0]                rad_s1,
	output logic [2:0][DATA_WIDTH:0]     mag_s1,
	output logic [2:0]                   sgn_s1
);
	import r2q_pkg::*;

	localparam logic signed [RW-1:0] ONE_Q = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

	logic signed [RW-1:0]     e00, e11, e22, tr, rad;
	logic signed [DATA_WIDTH:0] dzy, dxz, dyx, sxy, sxz, syz;
	logic signed [DATA_WIDTH:0] num [3];
	logic [1:0]               br;

	assign e00 = RW'(r00);
	assign e11 = RW'(r11);
	assign e22 = RW'(r22);
	assign tr  = e00 + e11 + e22;

	assign dzy = (DATA_WIDTH+1)'(r21) - (DATA_WIDTH+1)'(r12);
	assign dxz = (DATA_WIDTH+1)'(r02) - (DATA_WIDTH+1)'(r20);
	assign dyx = (DATA_WIDTH+1)'(r10) - (DATA_WIDTH+1)'(r01);
	assign sxy = (DATA_WIDTH+1)'(r01) + (DATA_WIDTH+1)'(r10);
	assign sxz = (DATA_WIDTH+1)'(r02) + (DATA_WIDTH+1)'(r20);
	assign syz = (DATA_WIDTH+1)'(r12) + (DATA_WIDTH+1)'(r21);

	always_comb begin
		if (tr > 0) begin
			br = BR_TRACE;
		end else if (e00 > e11 && e00 > e22) begin
			br = BR_X;
		end else if (e11 > e22) begin
			br = BR_Y;
		end else begin
			br = BR_Z;
		end
		case (br)
			BR_TRACE: begin
				rad = ONE_Q + tr;
				num[0] = dzy; num[1] = dxz; num[2] = dyx;
			end
			BR_X: begin
				rad = ONE_Q + e00 - e11 - e22;
				num[0] = sxy; num[1] = sxz; num[2] = dzy;
			end
			BR_Y: begin
				rad = ONE_Q + e11 - e00 - e22;
				num[0] = sxy; num[1] = syz; num[2] = dxz;
			end
			default: begin
				rad = ONE_Q + e22 - e00 - e11;
				num[0] = sxz; num[1] = syz; num[2] = dyx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.branch <= br;
			ctl_s1.bad    <= rad[RW-1] || (rad == '0);
			rad_s1        <= rad[RW-2:0];
			for (int l = 0; l < 3; l++) begin
				sgn_s1[l] <= num[l][DATA_WIDTH];
				mag_s1[l] <= num[l][DATA_WIDTH] ? -num[l] : num[l];
			end
		end
	end
endmodule

>>> hw/rtl/r2q_sqrt.sv
// ----------------------------------------------------------------------------
// r2q_sqrt
// Pipelined integer square root of rad * 2^FRAC_BITS, one root bit a stage.
// ----------------------------------------------------------------------------
module r2q_sqrt #(
	parameter int RADW      = r2q_pkg::DATA_WIDTH_DEF + 2,
	parameter int FRAC_BITS = r2q_pkg::FRAC_BITS_DEF,
	parameter int SQ        = (RADW + FRAC_BITS + 1) / 2,
	parameter int SBW       = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [RADW-1:0] rad,
	input  logic [SBW-1:0]  sb_in,
	output logic            out_valid,
	output logic [SQ-1:0]   root,
	output logic [SBW-1:0]  sb_out
);
	import r2q_pkg::*;

	localparam int NE = 2 * SQ;

	logic [SQ-1:0]  rem_s  [0:SQ-1];
	logic [SQ-1:0]  root_s [0:SQ];
	logic [NE-1:0]  n_s    [0:SQ-1];
	logic [SBW-1:0] sb_s   [0:SQ];
	logic           v_s    [0:SQ];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign n_s[0]    = NE'({rad, {FRAC_BITS{1'b0}}});
	assign sb_s[0]   = sb_in;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < SQ; k++) begin : g_stage
		logic [SQ+1:0] cur, trial;
		logic          ge;

		assign cur   = {rem_s[k], n_s[k][NE-1:NE-2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_s[k][SQ-2:0], ge};
				sb_s[k+1]   <= sb_s[k];
			end
		end

		if (k < SQ - 1) begin : g_rem
			logic [SQ+1:0] nxt;
			assign nxt = ge ? (cur - trial) : cur;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= nxt[SQ-1:0];
					n_s[k+1]   <= {n_s[k][NE-3:0], 2'b00};
				end
			end
		end
	end

	assign out_valid = v_s[SQ];
	assign root      = root_s[SQ];
	assign sb_out    = sb_s[SQ];
endmodule

>>> hw/rtl/r2q_div.sv
// ----------------------------------------------------------------------------
// r2q_div
// Three-lane pipelined restoring divider: (mag*2^F + root) / (2*root).
// ----------------------------------------------------------------------------
module r2q_div #(
	parameter int DATA_WIDTH = r2q_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = r2q_pkg::FRAC_BITS_DEF,
	parameter int SQ         = 16,
	parameter int SBW        = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [SQ-1:0]              root,
	input  logic [2:0][DATA_WIDTH:0]   mag,
	input  logic [SBW-1:0]             sb_in,
	output logic                       out_valid,
	output logic [2:0][DATA_WIDTH-1:0] q,
	output logic [2:0]                 ovf,
	output logic [SBW-1:0]             sb_out
);
	import r2q_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int DA = W + 1 + FRAC_BITS;
	localparam int DB = ((DA > SQ) ? DA : SQ) + 1;
	localparam int CW = (DB > SQ + 1 + W) ? DB : (SQ + 1 + W);

	logic [CW-1:0]     den_s [0:W-1];
	logic [2:0][CW-1:0] rem_s [0:W-1];
	logic [2:0][W-1:0]  q_s   [0:W];
	logic [2:0]        ovf_s [0:W];
	logic [SBW-1:0]    sb_s  [0:W];
	logic              v_s   [0:W];

	logic [CW-1:0]      den_in;
	logic [2:0][CW-1:0] d_in;
	logic [2:0]         ovf_in;

	assign den_in = CW'({root, 1'b0});
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			d_in[l]   = CW'({mag[l], {FRAC_BITS{1'b0}}}) + CW'(root);
			ovf_in[l] = (d_in[l] >= (den_in << W));
		end
	end

	assign q_s[0] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den_in;
			rem_s[0] <= d_in;
			ovf_s[0] <= ovf_in;
			sb_s[0]  <= sb_in;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_stage
		localparam int B = W - j;
		logic [CW-1:0]      sub;
		logic [2:0]         ge;

		assign sub = den_s[j-1] << B;
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				ge[l] = (rem_s[j-1][l] >= sub);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					q_s[j][l] <= {q_s[j-1][l][W-2:0], ge[l]};
				end
				ovf_s[j] <= ovf_s[j-1];
				sb_s[j]  <= sb_s[j-1];
			end
		end

		if (j < W) begin : g_carry
			logic [2:0][CW-1:0] nxt;

			always_comb begin
				for (int l = 0; l < 3; l++) begin
					nxt[l] = ge[l] ? (rem_s[j-1][l] - sub) : rem_s[j-1][l];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[j] <= den_s[j-1];
					rem_s[j] <= nxt;
				end
			end
		end
	end

	assign out_valid = v_s[W];
	assign q         = q_s[W];
	assign ovf       = ovf_s[W];
	assign sb_out    = sb_s[W];
endmodule

>>> hw/rtl/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Fixed-point rotation matrix to quaternion conversion, fully pipelined.
// ----------------------------------------------------------------------------
// usage
//   mtx  : sink channel, one 3x3 matrix per transaction (nine signed entries)
//   quat : source channel, one quaternion per transaction, with the branch
//          that was used and a flag for a non-positive radicand
//   one transaction is taken every cycle when the receiver keeps up
//   SQ = (RW - 1 + FRAC_BITS + 1) / 2 root bits and RW = max(DATA_WIDTH,
//   FRAC_BITS) + 3, so SQ is 16 at the default 16/14 format; the pipe is
//   the front stage, the square root stages (one root bit each), the
//   divider stages (one quotient bit each) and the output register
//   the whole pipe advances together; while quat is stalled with a result
//   waiting, mtx.ready is low and every stage holds its contents
//   reset clears all valid bits; the data path has no reset and no state
//   is kept between matrices
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core #(
	parameter int DATA_WIDTH = r2q_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = r2q_pkg::FRAC_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	r2q_mtx_if.sink      mtx,
	r2q_quat_if.source   quat
);
	import r2q_pkg::*;

	// working widths
	localparam int DW   = DATA_WIDTH;
	localparam int RW   = ((DW > FRAC_BITS) ? DW : FRAC_BITS) + 3;
	localparam int RADW = RW - 1;
	localparam int SQ   = (RADW + FRAC_BITS + 1) / 2;
	localparam int XW   = ((SQ > DW) ? SQ : DW) + 1;
	localparam int CTLW = $bits(r2q_ctl_t);
	localparam int SB1W = CTLW + 3 + 3 * (DW + 1);
	localparam int SB2W = CTLW + 3 + SQ;

	localparam logic [DW-1:0] MAX_D = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_D = {1'b1, {(DW-1){1'b0}}};
	localparam logic [XW-1:0] MAX_X = XW'(MAX_D);

	// global advance: the pipe moves unless a finished result is stuck
	logic en;
	logic out_v_q;

	assign en        = !out_v_q || quat.ready;
	assign mtx.ready = en;

	// stage 1: branch, radicand, numerators
	logic                v_s1;
	r2q_ctl_t            ctl_s1;
	logic [RADW-1:0]     rad_s1;
	logic [2:0][DW:0]    mag_s1;
	logic [2:0]          sgn_s1;

	r2q_front #(
		.DATA_WIDTH (DW),
		.FRAC_BITS  (FRAC_BITS),
		.RW         (RW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mtx.valid),
		.r00      (mtx.r00), .r01 (mtx.r01), .r02 (mtx.r02),
		.r10      (mtx.r10), .r11 (mtx.r11), .r12 (mtx.r12),
		.r20      (mtx.r20), .r21 (mtx.r21), .r22 (mtx.r22),
		.v_s1     (v_s1),
		.ctl_s1   (ctl_s1),
		.rad_s1   (rad_s1),
		.mag_s1   (mag_s1),
		.sgn_s1   (sgn_s1)
	);

	// square root stages, numerators ride along
	logic              v_sq;
	logic [SQ-1:0]     root_sq;
	logic [SB1W-1:0]   sb1_out;
	r2q_ctl_t          ctl_sq;
	logic [2:0]        sgn_sq;
	logic [2:0][DW:0]  mag_sq;

	r2q_sqrt #(
		.RADW      (RADW),
		.FRAC_BITS (FRAC_BITS),
		.SQ        (SQ),
		.SBW       (SB1W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.rad       (rad_s1),
		.sb_in     ({ctl_s1, sgn_s1, mag_s1}),
		.out_valid (v_sq),
		.root      (root_sq),
		.sb_out    (sb1_out)
	);

	assign {ctl_sq, sgn_sq, mag_sq} = sb1_out;

	// divider stages for the three cross terms, root rides along
	logic              v_dv;
	logic [2:0][DW-1:0] q_dv;
	logic [2:0]        ovf_dv;
	logic [SB2W-1:0]   sb2_out;
	r2q_ctl_t          ctl_dv;
	logic [2:0]        sgn_dv;
	logic [SQ-1:0]     root_dv;

	r2q_div #(
		.DATA_WIDTH (DW),
		.FRAC_BITS  (FRAC_BITS),
		.SQ         (SQ),
		.SBW        (SB2W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_sq),
		.root      (root_sq),
		.mag       (mag_sq),
		.sb_in     ({ctl_sq, sgn_sq, root_sq}),
		.out_valid (v_dv),
		.q         (q_dv),
		.ovf       (ovf_dv),
		.sb_out    (sb2_out)
	);

	assign {ctl_dv, sgn_dv, root_dv} = sb2_out;

	// back end: chosen component s/4 rounded half up, saturation
	logic [XW-1:0]      ch_ext;
	logic [DW-1:0]      ch_sat;
	logic [2:0][DW-1:0] cr_sat;
	logic [DW-1:0]      sx, sy, sz, sw;

	assign ch_ext = (XW'(root_dv) + XW'(1)) >> 1;
	assign ch_sat = (ch_ext > MAX_X) ? MAX_D : ch_ext[DW-1:0];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (!sgn_dv[l]) begin
				cr_sat[l] = (ovf_dv[l] || q_dv[l][DW-1]) ? MAX_D : q_dv[l];
			end else if (ovf_dv[l] || (q_dv[l][DW-1] && (q_dv[l][DW-2:0] != '0))) begin
				cr_sat[l] = MIN_D;
			end else begin
				cr_sat[l] = -q_dv[l];
			end
		end
	end

	// put the chosen component in its slot, cross terms fill the rest in order
	always_comb begin
		case (ctl_dv.branch)
			BR_TRACE: begin
				sx = cr_sat[0]; sy = cr_sat[1]; sz = cr_sat[2]; sw = ch_sat;
			end
			BR_X: begin
				sx = ch_sat; sy = cr_sat[0]; sz = cr_sat[1]; sw = cr_sat[2];
			end
			BR_Y: begin
				sx = cr_sat[0]; sy = ch_sat; sz = cr_sat[1]; sw = cr_sat[2];
			end
			default: begin
				sx = cr_sat[0]; sy = cr_sat[1]; sz = ch_sat; sw = cr_sat[2];
			end
		endcase
	end

	// output register
	logic [DW-1:0] qx_q, qy_q, qz_q, qw_q;
	logic [1:0]    br_q;
	logic          bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q  <= ctl_dv.bad ? '0 : sx;
			qy_q  <= ctl_dv.bad ? '0 : sy;
			qz_q  <= ctl_dv.bad ? '0 : sz;
			qw_q  <= ctl_dv.bad ? '0 : sw;
			br_q  <= ctl_dv.branch;
			bad_q <= ctl_dv.bad;
		end
	end

	assign quat.valid        = out_v_q;
	assign quat.qx           = qx_q;
	assign quat.qy           = qy_q;
	assign quat.qz           = qz_q;
	assign quat.qw           = qw_q;
	assign quat.branch_taken = br_q;
	assign quat.bad_input    = bad_q;

`ifndef SYNTH
	// a flagged transaction carries an all-zero quaternion
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.bad_input |->
			quat.qx == '0 && quat.qy == '0 && quat.qz == '0 && quat.qw == '0)
		else $error("flagged result with nonzero quaternion");

	// the trace branch always has a positive radicand
	a_trace_ok: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.branch_taken == BR_TRACE |-> !quat.bad_input)
		else $error("bad radicand in trace branch");

	// the scalar from the trace branch is never negative
	a_trace_w: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.branch_taken == BR_TRACE |-> !quat.qw[DW-1])
		else $error("negative w in trace branch");
`endif
endmodule
